FILE: src/envelope_shape_sample_macros.svh
// Assertion macros used by the envelope shaper port checker
`ifndef ENVELOPE_SHAPE_SAMPLE_MACROS_SVH
`define ENVELOPE_SHAPE_SAMPLE_MACROS_SVH

// same-cycle implication
`define ESS_ASSERT_IMP(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ESS_ASSERT_NXT(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ess_pkg.sv
// Types and constants for the envelope shaper
`default_nettype none

package ess_pkg;

    localparam int FRAC_BITS  = 15;
    localparam int MAX_FRAMES = 65536;

    localparam int IDX_W     = 16;
    localparam int LEN_W     = 17;
    localparam int LVL_W     = 16;
    localparam int ST_W      = 2;
    localparam int MODE_W    = 2;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 3;

    // quotient never exceeds 1.0, so one bit above the fraction
    localparam int QW     = FRAC_BITS + 1;
    localparam int REM_W  = LEN_W;
    localparam int PROD_W = LEN_W + LVL_W;

    localparam logic [LVL_W-1:0] ONE     = LVL_W'(1 << FRAC_BITS);
    localparam logic [LVL_W-1:0] SUS_DEF = LVL_W'(((333 << FRAC_BITS) + 500) / 1000);
    localparam logic [LEN_W-1:0] MAX_FC  = LEN_W'(MAX_FRAMES);

    localparam logic [MODE_W-1:0] MODE_AF   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ADSR = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_LONG  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd5;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [LEN_W-1:0]  frame_count;
        logic [LEN_W-1:0]  attack_len;
        logic [LEN_W-1:0]  decay_len;
        logic [LEN_W-1:0]  release_len;
        logic [LVL_W-1:0]  sustain_level;
    } t_cfg;

    // word moving along the divider row
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QW-1:0]    nq;
        logic [LEN_W-1:0] den;
        logic [LVL_W-1:0] base;
        logic [ST_W-1:0]  status;
    } t_div_word;

endpackage

`default_nettype wire

FILE: src/envelope_shape_sample.sv
// Envelope shaper top level: config registers, front end, divider row, output register
//
//  channel   dir  handshake            payload
//  -------   ---  -------------------  ---------------------------
//  sample    in   i_valid / o_stall    i_sample_index
//  level     out  o_valid / i_stall    o_level, o_status
//  config    in   i_cfg_we             i_cfg_index, i_cfg_data
//
// One word per clock while the output is not stalled; stages: decode, multiply,
// 16 divider cells (one quotient bit each), output register.
// Reset is synchronous and needs no clearing pass; config returns to defaults.
// A stalled result holds in the output register while empty stages upstream
// keep filling, so input is taken until every stage holds a word.
`default_nettype none

module envelope_shape_sample
    import ess_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [IDX_W-1:0]     i_sample_index,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [LVL_W-1:0]          o_level,
    output logic [ST_W-1:0]           o_status,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg       r_cfg;
    logic       front_ready;
    logic       w_valid [0:QW];
    logic       w_ready [0:QW];
    t_div_word  w_word  [0:QW];

    logic             out_ready;
    logic             r_out_valid;
    logic [LVL_W-1:0] r_level;
    logic [ST_W-1:0]  r_status;
    logic [LVL_W:0]   sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode          <= MODE_ADSR;
            r_cfg.frame_count   <= MAX_FC;
            r_cfg.attack_len    <= '0;
            r_cfg.decay_len     <= '0;
            r_cfg.release_len   <= '0;
            r_cfg.sustain_level <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:    r_cfg.mode          <= i_cfg_data[MODE_W-1:0];
                CFG_FRAMES:  r_cfg.frame_count   <= i_cfg_data[LEN_W-1:0];
                CFG_ATTACK:  r_cfg.attack_len    <= i_cfg_data[LEN_W-1:0];
                CFG_DECAY:   r_cfg.decay_len     <= i_cfg_data[LEN_W-1:0];
                CFG_RELEASE: r_cfg.release_len   <= i_cfg_data[LEN_W-1:0];
                CFG_SUSTAIN: r_cfg.sustain_level <= i_cfg_data[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    ess_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_sample_index (i_sample_index),
        .i_cfg          (r_cfg),
        .i_ready_next   (w_ready[0]),
        .o_ready        (front_ready),
        .o_valid        (w_valid[0]),
        .o_word         (w_word[0])
    );

    assign o_stall = !front_ready;

    for (genvar k = 0; k < QW; k++) begin : g_cell
        ess_div_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_valid      (w_valid[k]),
            .i_word       (w_word[k]),
            .i_ready_next (w_ready[k+1]),
            .o_ready      (w_ready[k]),
            .o_valid      (w_valid[k+1]),
            .o_word       (w_word[k+1])
        );
    end

    assign out_ready  = !r_out_valid || !i_stall;
    assign w_ready[QW] = out_ready;
    assign sum        = {1'b0, w_word[QW].base} + {1'b0, w_word[QW].nq};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= w_valid[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            r_level  <= sum[LVL_W-1:0];
            r_status <= w_word[QW].status;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_level  = r_level;
    assign o_status = r_status;

endmodule

`default_nettype wire

FILE: src/ess_front.sv
// Segment decode and numerator multiply ahead of the divider row
`default_nettype none

module ess_front
    import ess_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [IDX_W-1:0] i_sample_index,
    input  wire t_cfg             i_cfg,
    input  wire logic             i_ready_next,
    output logic                  o_ready,
    output logic                  o_valid,
    output t_div_word             o_word
);

    logic [LEN_W-1:0] fc;
    logic [LEN_W-1:0] idx;
    logic [LVL_W-1:0] sus0;
    logic [LVL_W-1:0] sus;
    logic [LEN_W:0]   ad;
    logic [LEN_W+1:0] adr;
    logic [LEN_W:0]   dec_num;
    logic [LEN_W:0]   rel_den;
    logic [LEN_W:0]   idx_r;
    logic             too_long;

    logic [LEN_W-1:0] n_num;
    logic [LVL_W-1:0] n_scale;
    logic [LEN_W-1:0] n_den;
    logic [LVL_W-1:0] n_base;
    logic [ST_W-1:0]  n_status;

    logic             r_a_valid;
    logic [LEN_W-1:0] r_num;
    logic [LVL_W-1:0] r_scale;
    logic [LEN_W-1:0] r_den;
    logic [LVL_W-1:0] r_base;
    logic [ST_W-1:0]  r_status;

    logic              r_b_valid;
    logic [PROD_W-1:0] r_prod;
    logic [LEN_W-1:0]  r_b_den;
    logic [LVL_W-1:0]  r_b_base;
    logic [ST_W-1:0]   r_b_status;

    logic              ready_a;
    logic              ready_b;
    logic [PROD_W-1:0] prod;

    assign ready_b = !r_b_valid || i_ready_next;
    assign ready_a = !r_a_valid || ready_b;
    assign o_ready = ready_a;

    assign fc      = (i_cfg.frame_count > MAX_FC) ? MAX_FC : i_cfg.frame_count;
    assign idx     = {1'b0, i_sample_index};
    assign sus0    = (i_cfg.sustain_level == '0) ? SUS_DEF : i_cfg.sustain_level;
    assign sus     = (sus0 > ONE) ? ONE : sus0;
    assign ad      = {1'b0, i_cfg.attack_len} + {1'b0, i_cfg.decay_len};
    assign adr     = {1'b0, ad} + {2'b0, i_cfg.release_len};
    assign dec_num = ad - {1'b0, idx};
    assign rel_den = {1'b0, fc} - ad;
    assign idx_r   = {1'b0, idx} + {1'b0, i_cfg.release_len};

    always_comb begin
        case (i_cfg.mode)
            MODE_AF:  too_long = i_cfg.attack_len > fc;
            MODE_ADR: too_long = ad >= {1'b0, fc};
            default:  too_long = adr >= {2'b0, fc};
        endcase

        // flagged words and the sustain hold divide zero by one
        n_num    = '0;
        n_scale  = ONE;
        n_den    = LEN_W'(1);
        n_base   = '0;
        n_status = ST_OK;

        if (too_long) begin
            n_status = ST_LONG;
        end else if (idx >= fc) begin
            n_status = ST_RANGE;
        end else if (idx < i_cfg.attack_len) begin
            n_num = idx;
            n_den = i_cfg.attack_len;
        end else if (i_cfg.mode == MODE_AF) begin
            n_num = fc - idx;
            n_den = fc - i_cfg.attack_len;
        end else if ({1'b0, idx} < ad) begin
            n_num   = dec_num[LEN_W-1:0];
            n_scale = ONE - sus;
            n_den   = i_cfg.decay_len;
            n_base  = sus;
        end else if (i_cfg.mode == MODE_ADR) begin
            n_num   = fc - idx;
            n_scale = sus;
            n_den   = rel_den[LEN_W-1:0];
        end else if (idx_r < {1'b0, fc}) begin
            n_base = sus;
        end else begin
            n_num   = fc - idx;
            n_scale = sus;
            n_den   = i_cfg.release_len;
        end
    end

    assign prod = PROD_W'(r_num) * PROD_W'(r_scale);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (ready_a) begin
                r_a_valid <= i_valid;
            end
            if (ready_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a) begin
            r_num    <= n_num;
            r_scale  <= n_scale;
            r_den    <= n_den;
            r_base   <= n_base;
            r_status <= n_status;
        end
        if (ready_b) begin
            r_prod     <= prod;
            r_b_den    <= r_den;
            r_b_base   <= r_base;
            r_b_status <= r_status;
        end
    end

    assign o_valid       = r_b_valid;
    assign o_word.rem    = r_prod[PROD_W-1:QW];
    assign o_word.nq     = r_prod[QW-1:0];
    assign o_word.den    = r_b_den;
    assign o_word.base   = r_b_base;
    assign o_word.status = r_b_status;

endmodule

`default_nettype wire

FILE: src/ess_div_cell.sv
// One restoring-division step: retires one quotient bit per cell
`default_nettype none

module ess_div_cell
    import ess_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    input  wire t_div_word i_word,
    input  wire logic      i_ready_next,
    output logic           o_ready,
    output logic           o_valid,
    output t_div_word      o_word
);

    logic [REM_W:0] trial;
    logic [REM_W:0] diff;
    logic           ge;
    t_div_word      n_word;
    logic           r_valid;
    t_div_word      r_word;

    assign o_ready = !r_valid || i_ready_next;

    // shift next numerator bit into the remainder, subtract if it fits
    assign trial = {i_word.rem, i_word.nq[QW-1]};
    assign diff  = trial - {1'b0, i_word.den};
    assign ge    = trial >= {1'b0, i_word.den};

    always_comb begin
        n_word     = i_word;
        n_word.rem = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
        n_word.nq  = {i_word.nq[QW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

FILE: src/ess_port_check.sv
// Port-level checks for the envelope shaper, bound to the top level
`default_nettype none
`include "envelope_shape_sample_macros.svh"

module ess_port_check
    import ess_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_valid,
    input wire logic             i_stall,
    input wire logic [LVL_W-1:0] o_level,
    input wire logic [ST_W-1:0]  o_status
);

    `ESS_ASSERT_NXT(a_out_hold, i_clk, !i_rst_n, o_valid && i_stall,
                    o_valid && $stable(o_level) && $stable(o_status),
                    "stalled result word changed")
    `ESS_ASSERT_IMP(a_flag_zero, i_clk, !i_rst_n, o_valid && (o_status != ST_OK),
                    o_level == '0, "flagged word carries a nonzero level")
    `ESS_ASSERT_IMP(a_level_max, i_clk, !i_rst_n, o_valid, o_level <= ONE,
                    "level above unity")
    `ESS_ASSERT_NXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, !o_valid,
                    "result valid straight after reset")

endmodule

bind envelope_shape_sample ess_port_check u_port_check (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_level  (o_level),
    .o_status (o_status)
);

`default_nettype wire
